/* hdl/lz4_block_sequence_decoder_assert.svh */
// Assertion macros used by the decoder's top-level RTL file.
`ifndef LZ4_BLOCK_SEQUENCE_DECODER_ASSERT_SVH
`define LZ4_BLOCK_SEQUENCE_DECODER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define LZ4BSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lz4 decoder check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define LZ4BSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lz4 decoder check failed");

`endif

/* hdl/lz4bsd_pkg.sv */
// Types and constants of the LZ4 block sequence decoder.
package lz4bsd_pkg;

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_LIT_EXT,
        PH_LITERALS,
        PH_OFF_LO,
        PH_OFF_HI,
        PH_MATCH_EXT,
        PH_COPY
    } phase_t;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_BUSY   = 2'd1;
    localparam logic [1:0] ERR_OFFSET = 2'd2;
    localparam logic [1:0] ERR_TRUNC  = 2'd3;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    localparam logic [7:0] BYTE_RUN    = 8'hff;
    localparam logic [3:0] NIBBLE_RUN  = 4'hf;
    localparam logic [3:0] MIN_MATCH   = 4'd4;

    // Result of one beat, passed from the parser to the data path.
    typedef struct packed {
        logic        is_copy;
        logic [7:0]  lit;
        logic [3:0]  count;
        logic [15:0] offset;
        logic        done;
        logic        pending;
        logic [1:0]  err;
    } step_t;

endpackage

/* hdl/lz4bsd_hist.sv */
// History ring: eight byte-wide banks, eight consecutive bytes read or written per cycle.
module lz4bsd_hist
    import lz4bsd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 65536
)
(
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [$clog2(HISTORY_DEPTH)-1:0]  rd_pos,
    input  logic                              wr_en,
    input  logic [$clog2(HISTORY_DEPTH)-1:0]  wr_pos,
    input  logic [3:0]                        wr_count,
    input  logic [8*LANES-1:0]                wr_data,
    output logic [8*LANES-1:0]                rd_data
);

    localparam int ROWS = HISTORY_DEPTH / LANES;
    localparam int RW   = $clog2(ROWS);

    logic [RW-1:0]     rd_row0;
    logic [RW-1:0]     rd_row1;
    logic [RW-1:0]     wr_row0;
    logic [RW-1:0]     wr_row1;
    logic [LANE_W-1:0] rd_lo_reg;
    logic [7:0]        bank_q [LANES];

    assign rd_row0 = RW'(rd_pos >> LANE_W);
    assign rd_row1 = (rd_row0 == RW'(ROWS - 1)) ? '0 : rd_row0 + RW'(1);
    assign wr_row0 = RW'(wr_pos >> LANE_W);
    assign wr_row1 = (wr_row0 == RW'(ROWS - 1)) ? '0 : wr_row0 + RW'(1);

    for (genvar k = 0; k < LANES; k++) begin : g_bank
        logic [7:0]        bank_mem [ROWS];
        logic [LANE_W-1:0] wr_lane;
        logic [RW-1:0]     rrow;
        logic [RW-1:0]     wrow;
        logic              we;

        assign wr_lane = LANE_W'(k) - wr_pos[LANE_W-1:0];
        assign rrow    = (LANE_W'(k) < rd_pos[LANE_W-1:0]) ? rd_row1 : rd_row0;
        assign wrow    = (LANE_W'(k) < wr_pos[LANE_W-1:0]) ? wr_row1 : wr_row0;
        assign we      = wr_en && ({1'b0, wr_lane} < wr_count);

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                bank_mem[wrow] <= wr_data[8*wr_lane +: 8];
            end
            if (rd_en)
            begin
                bank_q[k] <= bank_mem[rrow];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_lo_reg <= rd_pos[LANE_W-1:0];
        end
    end

    // rotate banks back into stream order
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            rd_data[8*i +: 8] = bank_q[LANE_W'(rd_lo_reg + LANE_W'(i))];
        end
    end

endmodule

/* hdl/lz4bsd_parse.sv */
// Sequence parser: token, lengths, offset and copy bookkeeping.
module lz4bsd_parse
    import lz4bsd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 65536,
    parameter int COPY_BYTES    = 8,
    parameter int LENGTH_WIDTH  = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              func,
    input  logic [7:0]                        in_byte,
    input  logic                              block_last,
    output step_t                             step,
    output logic [$clog2(HISTORY_DEPTH)-1:0]  wr_start,
    output logic [$clog2(HISTORY_DEPTH)-1:0]  src_start
);

    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int PW  = AW + 1;
    localparam int LW  = LENGTH_WIDTH;
    localparam int LW1 = LENGTH_WIDTH + 1;

    phase_t          phase_reg, phase_next;
    logic [3:0]      nibble_reg, nibble_next;
    logic [LW-1:0]   lit_reg, lit_next;
    logic [15:0]     offset_reg, offset_next;
    logic [LW-1:0]   mrem_reg, mrem_next;
    logic [AW-1:0]   wp_reg, wp_next;
    logic [PW-1:0]   bp_reg, bp_next;
    logic            endp_reg, endp_next;

    logic [3:0]      copy_n;
    logic [3:0]      adv;
    logic [LW1-1:0]  lit_add;
    logic [LW1-1:0]  mrem_add;
    logic [LW-1:0]   lit_dec;
    logic [LW-1:0]   mrem_left;
    logic [15:0]     off_full;
    logic            bad_off;
    logic            complete_ok;
    logic [PW-1:0]   wp_sum;
    logic [PW-1:0]   bp_sum;
    logic [PW-1:0]   src_sum;

    always_comb
    begin
        copy_n = 4'(COPY_BYTES);
        if (offset_reg < 16'(COPY_BYTES))
        begin
            copy_n = offset_reg[3:0];
        end
        if (mrem_reg < LW'(copy_n))
        begin
            copy_n = mrem_reg[3:0];
        end
    end

    assign lit_add   = {1'b0, lit_reg} + LW1'(in_byte);
    assign mrem_add  = {1'b0, mrem_reg} + LW1'(in_byte);
    assign lit_dec   = (lit_reg != '0) ? lit_reg - LW'(1) : lit_reg;
    assign mrem_left = mrem_reg - LW'(copy_n);
    assign off_full  = (phase_reg == PH_OFF_HI) ? {in_byte, offset_reg[7:0]} : offset_reg;
    assign bad_off   = (off_full == '0) || (PW'(off_full) > bp_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        lit_next    = lit_reg;
        offset_next = offset_reg;
        mrem_next   = mrem_reg;
        endp_next   = endp_reg;
        adv         = '0;
        complete_ok = 1'b0;
        step        = '0;
        step.lit    = in_byte;
        step.offset = offset_reg;

        if (func == FUNC_TICK)
        begin
            if (phase_reg == PH_COPY)
            begin
                step.is_copy = 1'b1;
                step.count   = copy_n;
                adv          = copy_n;
                mrem_next    = mrem_left;
                if (mrem_left == '0)
                begin
                    phase_next = PH_TOKEN;
                    step.done  = endp_reg;
                    endp_next  = 1'b0;
                end
            end
        end
        else if (phase_reg == PH_COPY)
        begin
            step.err = ERR_BUSY;
        end
        else
        begin
            case (phase_reg)
                PH_TOKEN:
                begin
                    nibble_next = in_byte[3:0];
                    lit_next    = LW'(in_byte[7:4]);
                    if (in_byte[7:4] == NIBBLE_RUN)
                    begin
                        phase_next = PH_LIT_EXT;
                    end
                    else if (in_byte[7:4] == 4'd0)
                    begin
                        phase_next  = PH_OFF_LO;
                        complete_ok = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_LITERALS;
                    end
                end
                PH_LIT_EXT:
                begin
                    lit_next = lit_add[LW] ? '1 : lit_add[LW-1:0];
                    if (in_byte != BYTE_RUN)
                    begin
                        phase_next = PH_LITERALS;
                    end
                end
                PH_LITERALS:
                begin
                    step.count = 4'd1;
                    adv        = 4'd1;
                    lit_next   = lit_dec;
                    if (lit_dec == '0)
                    begin
                        phase_next  = PH_OFF_LO;
                        complete_ok = 1'b1;
                    end
                end
                PH_OFF_LO:
                begin
                    offset_next = {8'd0, in_byte};
                    phase_next  = PH_OFF_HI;
                end
                PH_OFF_HI, PH_MATCH_EXT:
                begin
                    if (phase_reg == PH_OFF_HI)
                    begin
                        offset_next = off_full;
                        mrem_next   = LW'(nibble_reg) + LW'(MIN_MATCH);
                    end
                    else
                    begin
                        mrem_next = mrem_add[LW] ? '1 : mrem_add[LW-1:0];
                    end
                    if (phase_reg == PH_OFF_HI && nibble_reg == NIBBLE_RUN)
                    begin
                        phase_next = PH_MATCH_EXT;
                    end
                    else if (phase_reg == PH_MATCH_EXT && in_byte == BYTE_RUN)
                    begin
                        phase_next = PH_MATCH_EXT;
                    end
                    else
                    begin
                        complete_ok = 1'b1;
                        if (bad_off)
                        begin
                            phase_next = PH_TOKEN;
                            mrem_next  = '0;
                            step.done  = block_last;
                            step.err   = ERR_OFFSET;
                        end
                        else
                        begin
                            phase_next = PH_COPY;
                            endp_next  = block_last;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_TOKEN;
                end
            endcase

            if (block_last && step.err == ERR_NONE)
            begin
                if (complete_ok)
                begin
                    if (phase_next == PH_OFF_LO)
                    begin
                        phase_next = PH_TOKEN;
                        step.done  = 1'b1;
                    end
                end
                else
                begin
                    phase_next = PH_TOKEN;
                    lit_next   = '0;
                    mrem_next  = '0;
                    step.done  = 1'b1;
                    step.err   = ERR_TRUNC;
                end
            end
        end
        step.pending = (phase_next == PH_COPY);
    end

    assign wp_sum  = {1'b0, wp_reg} + PW'(adv);
    assign wp_next = (wp_sum >= PW'(HISTORY_DEPTH)) ? AW'(wp_sum - PW'(HISTORY_DEPTH))
                                                    : wp_sum[AW-1:0];
    assign bp_sum  = bp_reg + PW'(adv);
    assign bp_next = (bp_sum > PW'(HISTORY_DEPTH)) ? PW'(HISTORY_DEPTH) : bp_sum;
    assign src_sum = {1'b0, wp_reg} + PW'(HISTORY_DEPTH) - PW'(offset_reg);

    assign wr_start  = wp_reg;
    assign src_start = (src_sum >= PW'(HISTORY_DEPTH)) ? AW'(src_sum - PW'(HISTORY_DEPTH))
                                                       : src_sum[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TOKEN;
            nibble_reg <= '0;
            lit_reg    <= '0;
            offset_reg <= '0;
            mrem_reg   <= '0;
            wp_reg     <= '0;
            bp_reg     <= '0;
            endp_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            lit_reg    <= lit_next;
            offset_reg <= offset_next;
            mrem_reg   <= mrem_next;
            wp_reg     <= wp_next;
            bp_reg     <= bp_next;
            endp_reg   <= endp_next;
        end
    end

endmodule

/* hdl/lz4_block_sequence_decoder.sv */
// LZ4 block sequence decoder, top level.
// Takes one beat per cycle (a compressed byte or a copy tick) unless stalled and returns one
// registered result beat per input beat. Each tick copies up to min(COPY_BYTES, offset, bytes
// left) match bytes; the history ring is eight byte-wide banks, so any eight consecutive bytes
// are read in one access, and bytes written by the previous beat are forwarded from a register.
// The ring is not cleared after reset; offsets reaching beyond produced output are rejected.
module lz4_block_sequence_decoder
    import lz4bsd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 65536,
    parameter int COPY_BYTES    = 8,
    parameter int LENGTH_WIDTH  = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  in_byte,
    input  logic        block_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_bytes,
    output logic [3:0]  out_count,
    output logic        block_done,
    output logic        copy_pending,
    output logic [1:0]  error_code
);

`include "lz4_block_sequence_decoder_assert.svh"

    localparam int AW = $clog2(HISTORY_DEPTH);

    logic               accept;
    logic               s1_move;
    step_t              step;
    logic [AW-1:0]      wr_start;
    logic [AW-1:0]      src_start;
    logic [8*LANES-1:0] rd_data;
    logic [8*LANES-1:0] merged;

    logic               s1_valid_reg;
    step_t              s1_step_reg;
    logic [AW-1:0]      s1_wp_reg;
    logic [8*LANES-1:0] s1_fwd_bytes_reg;
    logic [3:0]         s1_fwd_cnt_reg;

    logic               out_valid_reg;
    logic [63:0]        out_bytes_reg;
    logic [3:0]         out_count_reg;
    logic               block_done_reg;
    logic               copy_pending_reg;
    logic [1:0]         error_code_reg;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;

    lz4bsd_parse #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COPY_BYTES    (COPY_BYTES),
        .LENGTH_WIDTH  (LENGTH_WIDTH)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (func),
        .in_byte    (in_byte),
        .block_last (block_last),
        .step       (step),
        .wr_start   (wr_start),
        .src_start  (src_start)
    );

    lz4bsd_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk      (clk),
        .rd_en    (accept),
        .rd_pos   (src_start),
        .wr_en    (s1_move),
        .wr_pos   (s1_wp_reg),
        .wr_count (s1_step_reg.count),
        .wr_data  (merged),
        .rd_data  (rd_data)
    );

    // bytes within the previous beat's write window come from the forward register
    always_comb
    begin
        merged = '0;
        if (s1_step_reg.is_copy)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (4'(i) < s1_step_reg.count)
                begin
                    if (s1_step_reg.offset <= 16'(i) + 16'(s1_fwd_cnt_reg))
                    begin
                        merged[8*i +: 8] = s1_fwd_bytes_reg[8*LANE_W'(16'(s1_fwd_cnt_reg)
                            + 16'(i) - s1_step_reg.offset) +: 8];
                    end
                    else
                    begin
                        merged[8*i +: 8] = rd_data[8*i +: 8];
                    end
                end
            end
        end
        else if (s1_step_reg.count != '0)
        begin
            merged[7:0] = s1_step_reg.lit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_step_reg      <= step;
            s1_wp_reg        <= wr_start;
            s1_fwd_bytes_reg <= merged;
            s1_fwd_cnt_reg   <= s1_move ? s1_step_reg.count : 4'd0;
        end
        if (s1_move)
        begin
            out_bytes_reg    <= merged;
            out_count_reg    <= s1_step_reg.count;
            block_done_reg   <= s1_step_reg.done;
            copy_pending_reg <= s1_step_reg.pending;
            error_code_reg   <= s1_step_reg.err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_bytes    = out_bytes_reg;
    assign out_count    = out_count_reg;
    assign block_done   = block_done_reg;
    assign copy_pending = copy_pending_reg;
    assign error_code   = error_code_reg;

    `LZ4BSD_ASSERT_NOW(a_count_cap, out_valid, out_count <= 4'(COPY_BYTES))
    `LZ4BSD_ASSERT_NOW(a_busy_quiet, out_valid && error_code == ERR_BUSY,
        out_count == 4'd0 && !block_done)
    `LZ4BSD_ASSERT_NEXT(a_accept_fill, accept, s1_valid_reg)

endmodule
